// ----- src/ppbb_pkg.sv -----
package ppbb_pkg;

   localparam int BANK_BYTES = 4096;
   localparam int BANKS      = 2;
   localparam int MEM_DEPTH  = BANKS * BANK_BYTES;
   localparam int ADDR_W     = $clog2(MEM_DEPTH);
   localparam int FILL_W     = $clog2(BANK_BYTES + 1);

   localparam int ACTION_W = 3;
   localparam int BYTE_W   = 8;
   localparam int LENGTH_W = 16;
   localparam int OFFSET_W = 12;
   localparam int STATUS_W = 2;
   localparam int SIZE_W   = 13;

   localparam int CMP_W = ((FILL_W > LENGTH_W) ? FILL_W : LENGTH_W) + 1;

   localparam logic [ACTION_W-1:0] ACT_WRITE   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_COMMIT  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_READ    = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_RELEASE = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CLEAR   = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                use_ram;
      logic                read_available;
      logic [SIZE_W-1:0]   read_size;
      logic                active_write_bank;
   } result_type;

endpackage

// ----- src/ppbb_if.sv -----
interface ppbb_req_if;
   logic                           valid;
   logic                           ready;
   logic [ppbb_pkg::ACTION_W-1:0]  action;
   logic [ppbb_pkg::BYTE_W-1:0]    data_byte;
   logic                           chunk_first;
   logic [ppbb_pkg::LENGTH_W-1:0]  chunk_length;
   logic [ppbb_pkg::OFFSET_W-1:0]  read_offset;

   modport source (output valid, action, data_byte, chunk_first, chunk_length, read_offset,
                   input ready);
   modport sink (input valid, action, data_byte, chunk_first, chunk_length, read_offset,
                 output ready);
endinterface

interface ppbb_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ppbb_pkg::STATUS_W-1:0]  status;
   logic [ppbb_pkg::BYTE_W-1:0]    read_byte;
   logic                           read_available;
   logic [ppbb_pkg::SIZE_W-1:0]    read_size;
   logic                           active_write_bank;

   modport source (output valid, status, read_byte, read_available, read_size,
                   active_write_bank, input ready);
   modport sink (input valid, status, read_byte, read_available, read_size,
                 active_write_bank, output ready);
endinterface

// ----- src/ppbb_ram.sv -----
module ppbb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata <= mem[addr];
      end
   end

endmodule

// ----- src/ping_pong_byte_buffer_core.sv -----
// a result word goes from its request word through the stage-one register, then the output register
// throughput: one request word per cycle unless a response stall backs up the pipe, set by the single memory port
// a read takes its byte from the registered bank memory output, the result then sits in an output register
// reset (synchronous, active high) clears fills, ready marks, chunk state and bank select
// bank memory is not cleared: no fill covers an unwritten entry, so no clearing pass
module ping_pong_byte_buffer_core (
   input  logic clock,
   input  logic reset,
   ppbb_req_if.sink   req_bus,
   ppbb_rsp_if.source rsp_bus
);

   logic [ppbb_pkg::FILL_W-1:0] fill_ff [ppbb_pkg::BANKS];
   logic [ppbb_pkg::FILL_W-1:0] fill_in [ppbb_pkg::BANKS];
   logic [ppbb_pkg::BANKS-1:0]  ready_ff, ready_in;
   logic                        sel_ff, sel_in;
   logic                        accepting_ff, accepting_in;
   logic [ppbb_pkg::FILL_W-1:0] left_ff, left_in;

   logic                        s1_valid_ff, s1_valid_in;
   ppbb_pkg::result_type        s1_ff, s1_in;
   logic                        out_valid_ff, out_valid_in;
   ppbb_pkg::result_type        out_ff, out_in;
   logic [ppbb_pkg::BYTE_W-1:0] out_byte_ff, out_byte_in;

   logic                        accept, s1_move;
   logic                        ram_we, ram_re;
   logic [ppbb_pkg::ADDR_W-1:0] ram_addr;
   logic [ppbb_pkg::BYTE_W-1:0] ram_rdata;

   logic                        w, r, r_after;
   logic [ppbb_pkg::CMP_W-1:0]  fit_sum;
   logic                        first_ok, next_ok;

   assign s1_move        = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready  = !s1_valid_ff || s1_move;
   assign accept         = req_bus.valid && req_bus.ready;

   assign w = sel_ff;
   assign r = !sel_ff;
   assign fit_sum = ppbb_pkg::CMP_W'(fill_ff[w]) + ppbb_pkg::CMP_W'(req_bus.chunk_length);
   assign first_ok = (req_bus.chunk_length != '0)
                  && (ppbb_pkg::CMP_W'(req_bus.chunk_length)
                      <= ppbb_pkg::CMP_W'(ppbb_pkg::BANK_BYTES))
                  && !ready_ff[w]
                  && (fit_sum <= ppbb_pkg::CMP_W'(ppbb_pkg::BANK_BYTES));
   assign next_ok = accepting_ff && (left_ff != '0) && !ready_ff[w]
                 && (ppbb_pkg::CMP_W'(fill_ff[w]) < ppbb_pkg::CMP_W'(ppbb_pkg::BANK_BYTES));

   always_comb begin
      fill_in      = fill_ff;
      ready_in     = ready_ff;
      sel_in       = sel_ff;
      accepting_in = accepting_ff;
      left_in      = left_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_addr     = ppbb_pkg::ADDR_W'(w ? ppbb_pkg::BANK_BYTES : 0)
                   + ppbb_pkg::ADDR_W'(fill_ff[w]);
      s1_in        = '0;
      s1_in.status = ppbb_pkg::STATUS_OK;

      if (accept) begin
         unique case (req_bus.action)
            ppbb_pkg::ACT_WRITE: begin
               if (req_bus.chunk_first ? first_ok : next_ok) begin
                  ram_we     = 1'b1;
                  fill_in[w] = fill_ff[w] + 1'b1;
                  if (req_bus.chunk_first) begin
                     left_in = ppbb_pkg::FILL_W'(req_bus.chunk_length - 1'b1);
                  end else begin
                     left_in = left_ff - 1'b1;
                  end
                  accepting_in = (left_in != '0);
               end else begin
                  s1_in.status = ppbb_pkg::STATUS_REJECTED;
                  accepting_in = 1'b0;
                  left_in      = '0;
               end
            end
            ppbb_pkg::ACT_COMMIT: begin
               accepting_in = 1'b0;
               left_in      = '0;
               ready_in[w]  = 1'b1;
               if (!ready_ff[r]) begin
                  sel_in = r;
               end
            end
            ppbb_pkg::ACT_READ: begin
               ram_addr = ppbb_pkg::ADDR_W'(r ? ppbb_pkg::BANK_BYTES : 0)
                        + ppbb_pkg::ADDR_W'(req_bus.read_offset);
               if (!ready_ff[r]) begin
                  s1_in.status = ppbb_pkg::STATUS_EMPTY;
               end else if ((ppbb_pkg::CMP_W'(req_bus.read_offset)
                             < ppbb_pkg::CMP_W'(fill_ff[r]))
                         && (ppbb_pkg::CMP_W'(req_bus.read_offset)
                             < ppbb_pkg::CMP_W'(ppbb_pkg::BANK_BYTES))) begin
                  ram_re        = 1'b1;
                  s1_in.use_ram = 1'b1;
               end
            end
            ppbb_pkg::ACT_RELEASE: begin
               fill_in[r]  = '0;
               ready_in[r] = 1'b0;
            end
            ppbb_pkg::ACT_CLEAR: begin
               fill_in[0]   = '0;
               fill_in[1]   = '0;
               ready_in     = '0;
               sel_in       = 1'b0;
               accepting_in = 1'b0;
               left_in      = '0;
            end
            default: begin
            end
         endcase
      end

      r_after                 = !sel_in;
      s1_in.read_available    = ready_in[r_after];
      s1_in.read_size         = ready_in[r_after] ? ppbb_pkg::SIZE_W'(fill_in[r_after]) : '0;
      s1_in.active_write_bank = sel_in;
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      out_byte_in  = out_byte_ff;
      if (s1_move) begin
         out_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            out_in      = s1_ff;
            out_byte_in = s1_ff.use_ram ? ram_rdata : '0;
         end
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff[0]   <= '0;
         fill_ff[1]   <= '0;
         ready_ff     <= '0;
         sel_ff       <= 1'b0;
         accepting_ff <= 1'b0;
         left_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         ready_ff     <= ready_in;
         sel_ff       <= sel_in;
         accepting_ff <= accepting_in;
         left_ff      <= left_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      out_ff      <= out_in;
      out_byte_ff <= out_byte_in;
   end

   ppbb_ram #(
      .WIDTH(ppbb_pkg::BYTE_W),
      .DEPTH(ppbb_pkg::MEM_DEPTH)
   ) u_bank_ram (
      .clock(clock),
      .we   (ram_we),
      .re   (ram_re),
      .addr (ram_addr),
      .wdata(req_bus.data_byte),
      .rdata(ram_rdata)
   );

   assign rsp_bus.valid             = out_valid_ff;
   assign rsp_bus.status            = out_ff.status;
   assign rsp_bus.read_byte         = out_byte_ff;
   assign rsp_bus.read_available    = out_ff.read_available;
   assign rsp_bus.read_size         = out_ff.read_size;
   assign rsp_bus.active_write_bank = out_ff.active_write_bank;

   // pending result word survives an output stall
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff && $stable(s1_ff))
      else $error("pending result lost");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (ppbb_pkg::CMP_W'(fill_ff[0]) <= ppbb_pkg::CMP_W'(ppbb_pkg::BANK_BYTES))
      && (ppbb_pkg::CMP_W'(fill_ff[1]) <= ppbb_pkg::CMP_W'(ppbb_pkg::BANK_BYTES)))
      else $error("bank fill past capacity");

   a_chunk_count: assert property (@(posedge clock) disable iff (reset)
      accepting_ff |-> left_ff != '0)
      else $error("open chunk with no bytes left");

   a_no_write_ready: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !ready_ff[sel_ff])
      else $error("write into a ready bank");

   a_switch_cause: assert property (@(posedge clock) disable iff (reset)
      !$stable(sel_ff) |-> $past(reset) || ($past(accept)
         && ($past(req_bus.action) == ppbb_pkg::ACT_COMMIT
             || $past(req_bus.action) == ppbb_pkg::ACT_CLEAR)))
      else $error("bank switch without commit or clear");

endmodule
